/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the multi-axis PID step.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MAPID_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

`define MAPID_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`else

`define MAPID_ASSERT_SAME(lbl, clk, rstn, ante, cons)

`define MAPID_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/mapid_pkg.sv */
// Types, widths and register codes of the multi-axis PID step.
// No dependencies; used by the interfaces and every module.
package mapid_pkg;

    localparam int NUM_AXES     = 3;
    localparam int CH_W         = 2;
    localparam int SAMPLE_W     = 16;
    localparam int DIFF_W       = SAMPLE_W + 1;
    localparam int GAIN_W       = 16;
    localparam int LIMIT_W      = 32;
    localparam int INTEG_W      = 32;
    localparam int PROD_W       = GAIN_W + DIFF_W;
    localparam int ACC_SUM_W    = PROD_W + 1;
    localparam int DRIVE_SUM_W  = PROD_W + 2;
    localparam int DRIVE_W      = 40;
    localparam int GAINS_W      = 3 * GAIN_W;
    localparam int LIMITS_W     = 2 * LIMIT_W;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    typedef logic [CH_W-1:0]               channel_t;
    typedef logic signed [SAMPLE_W-1:0]    sample_t;
    typedef logic signed [GAIN_W-1:0]      gain_t;
    typedef logic signed [LIMIT_W-1:0]     limit_t;
    typedef logic signed [INTEG_W-1:0]     integ_t;
    typedef logic signed [DRIVE_W-1:0]     drive_t;
    typedef logic [CFG_IDX_W-1:0]          cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]         cfg_data_t;

    localparam channel_t CH_PITCH = 2'd0;
    localparam channel_t CH_ROLL  = 2'd1;
    localparam channel_t CH_YAW   = 2'd2;
    localparam channel_t CH_NONE  = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAINS_PITCH,
        REG_GAINS_ROLL,
        REG_GAINS_YAW,
        REG_LIMITS_PITCH,
        REG_LIMITS_ROLL,
        REG_LIMITS_YAW
    } reg_index_e;

    typedef struct packed {
        gain_t  kp;
        gain_t  ki;
        gain_t  kd;
        limit_t hi;
        limit_t lo;
    } axis_cfg_t;

    typedef struct packed {
        integ_t integ;
        drive_t drive;
    } pid_result_t;

endpackage

/* rtl/mapid_if.sv */
// Handshake channels of the multi-axis PID step: samples, results and configuration.
// Depends on mapid_pkg.
interface mapid_in_if;
    import mapid_pkg::*;
    logic     valid;
    logic     ready;
    channel_t channel;
    sample_t  measurement;
    sample_t  target;

    modport source (output valid, output channel, output measurement, output target,
                    input ready);
    modport sink   (input valid, input channel, input measurement, input target,
                    output ready);
endinterface

interface mapid_out_if;
    import mapid_pkg::*;
    logic   valid;
    logic   ready;
    drive_t drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

interface mapid_cfg_if;
    import mapid_pkg::*;
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/mapid_cfg_regs.sv */
// Gain and integral limit registers for the three axes, with per-channel readout.
// Depends on mapid_pkg.
module mapid_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  mapid_pkg::cfg_index_t wr_index,
    input  mapid_pkg::cfg_data_t  wr_data,
    input  mapid_pkg::channel_t   rd_channel,
    output mapid_pkg::axis_cfg_t  rd_cfg
);
    import mapid_pkg::*;

    logic [GAINS_W-1:0]  gains_reg  [NUM_AXES];
    logic [LIMITS_W-1:0] limits_reg [NUM_AXES];
    logic [GAINS_W-1:0]  gains_sel;
    logic [LIMITS_W-1:0] limits_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                gains_reg[k]  <= '0;
                limits_reg[k] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_GAINS_PITCH:  gains_reg[0]  <= wr_data[GAINS_W-1:0];
                REG_GAINS_ROLL:   gains_reg[1]  <= wr_data[GAINS_W-1:0];
                REG_GAINS_YAW:    gains_reg[2]  <= wr_data[GAINS_W-1:0];
                REG_LIMITS_PITCH: limits_reg[0] <= wr_data[LIMITS_W-1:0];
                REG_LIMITS_ROLL:  limits_reg[1] <= wr_data[LIMITS_W-1:0];
                REG_LIMITS_YAW:   limits_reg[2] <= wr_data[LIMITS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (rd_channel)
            CH_PITCH:
            begin
                gains_sel  = gains_reg[0];
                limits_sel = limits_reg[0];
            end
            CH_ROLL:
            begin
                gains_sel  = gains_reg[1];
                limits_sel = limits_reg[1];
            end
            CH_YAW:
            begin
                gains_sel  = gains_reg[2];
                limits_sel = limits_reg[2];
            end
            default:
            begin
                gains_sel  = '0;
                limits_sel = '0;
            end
        endcase
    end

    assign rd_cfg.kp = gain_t'(gains_sel[3*GAIN_W-1:2*GAIN_W]);
    assign rd_cfg.ki = gain_t'(gains_sel[2*GAIN_W-1:GAIN_W]);
    assign rd_cfg.kd = gain_t'(gains_sel[GAIN_W-1:0]);
    assign rd_cfg.hi = limit_t'(limits_sel[2*LIMIT_W-1:LIMIT_W]);
    assign rd_cfg.lo = limit_t'(limits_sel[LIMIT_W-1:0]);

endmodule

/* rtl/mapid_datapath.sv */
// One PID step: error, clamped integral update and drive with derivative on measurement.
// Depends on mapid_pkg; purely combinational.
module mapid_datapath (
    input  mapid_pkg::axis_cfg_t   cfg,
    input  mapid_pkg::sample_t     measurement,
    input  mapid_pkg::sample_t     target,
    input  mapid_pkg::sample_t     prev_meas,
    input  mapid_pkg::integ_t      integ,
    output mapid_pkg::pid_result_t res
);
    import mapid_pkg::*;

    logic signed [DIFF_W-1:0]      err;
    logic signed [DIFF_W-1:0]      dmeas;
    logic signed [PROD_W-1:0]      p_prod;
    logic signed [PROD_W-1:0]      i_prod;
    logic signed [PROD_W-1:0]      d_prod;
    logic signed [ACC_SUM_W-1:0]   acc_sum;
    logic signed [ACC_SUM_W-1:0]   hi_ext;
    logic signed [ACC_SUM_W-1:0]   lo_ext;
    integ_t                        acc_clamp;
    logic signed [DRIVE_SUM_W-1:0] drive_sum;

    always_comb
    begin
        err     = DIFF_W'(target) - DIFF_W'(measurement);
        dmeas   = DIFF_W'(measurement) - DIFF_W'(prev_meas);
        p_prod  = PROD_W'(cfg.kp) * PROD_W'(err);
        i_prod  = PROD_W'(cfg.ki) * PROD_W'(err);
        d_prod  = PROD_W'(cfg.kd) * PROD_W'(dmeas);
        acc_sum = ACC_SUM_W'(integ) + ACC_SUM_W'(i_prod);
        hi_ext  = ACC_SUM_W'(cfg.hi);
        lo_ext  = ACC_SUM_W'(cfg.lo);

        // The upper-limit test comes first: with crossed limits, a sum above hi gives hi and any other sum gives lo.
        if (acc_sum > hi_ext)
        begin
            acc_clamp = cfg.hi;
        end
        else if (acc_sum < lo_ext)
        begin
            acc_clamp = cfg.lo;
        end
        else
        begin
            acc_clamp = integ_t'(acc_sum[INTEG_W-1:0]);
        end

        drive_sum = DRIVE_SUM_W'(p_prod) + DRIVE_SUM_W'(acc_clamp) - DRIVE_SUM_W'(d_prod);
        res.integ = acc_clamp;
        res.drive = DRIVE_W'(drive_sum);
    end

endmodule

/* rtl/multi_axis_pid_step.sv */
// Top level of the three-axis PID step with input and result registers.
// Depends on mapid_pkg, mapid_if, mapid_cfg_regs, mapid_datapath and assert_macros.svh.
//
// Each sample word names an axis (pitch, roll or yaw) and carries a measurement and a
// setpoint; one drive word comes back for it, in order. A sample is captured in an input
// register, the whole PID step is computed in one pass of combinational logic and the drive
// lands in a result register; while the result side is not stalled, the block takes one sample
// every cycle, also for the same axis back to back. The input register takes a new sample
// while a drive waits to be read only if it is empty; a stalled result holds a full one.
// A sample for the unused channel code returns a zero drive and leaves all axis state alone.
// The user must write gains and limits through the configuration channel only while the block
// is idle; the block itself does not enforce this. That channel is always ready.
`include "assert_macros.svh"

module multi_axis_pid_step (
    input logic           clk,
    input logic           rst_n,
    mapid_in_if.sink      sample,
    mapid_out_if.source   result,
    mapid_cfg_if.sink     cfg
);
    import mapid_pkg::*;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    channel_t    s1_ch_reg;
    channel_t    s1_ch_next;
    sample_t     s1_meas_reg;
    sample_t     s1_meas_next;
    sample_t     s1_tgt_reg;
    sample_t     s1_tgt_next;
    logic        res_valid_reg;
    logic        res_valid_next;
    drive_t      res_drive_reg;
    drive_t      res_drive_next;
    integ_t      integ_reg [NUM_AXES];
    sample_t     prev_reg  [NUM_AXES];
    integ_t      integ_sel;
    sample_t     prev_sel;
    logic        advance;
    logic        accept;
    logic        axis_ok;
    axis_cfg_t   axis_cfg;
    pid_result_t step_res;

    assign cfg.ready    = 1'b1;
    assign advance      = s1_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;
    assign accept       = sample.valid && sample.ready;
    assign axis_ok      = (s1_ch_reg != CH_NONE);

    mapid_cfg_regs u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cfg.valid),
        .wr_index   (cfg.index),
        .wr_data    (cfg.data),
        .rd_channel (s1_ch_reg),
        .rd_cfg     (axis_cfg)
    );

    always_comb
    begin
        case (s1_ch_reg)
            CH_PITCH:
            begin
                integ_sel = integ_reg[0];
                prev_sel  = prev_reg[0];
            end
            CH_ROLL:
            begin
                integ_sel = integ_reg[1];
                prev_sel  = prev_reg[1];
            end
            CH_YAW:
            begin
                integ_sel = integ_reg[2];
                prev_sel  = prev_reg[2];
            end
            default:
            begin
                integ_sel = '0;
                prev_sel  = '0;
            end
        endcase
    end

    mapid_datapath u_datapath (
        .cfg         (axis_cfg),
        .measurement (s1_meas_reg),
        .target      (s1_tgt_reg),
        .prev_meas   (prev_sel),
        .integ       (integ_sel),
        .res         (step_res)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_ch_next     = s1_ch_reg;
        s1_meas_next   = s1_meas_reg;
        s1_tgt_next    = s1_tgt_reg;
        res_valid_next = res_valid_reg;
        res_drive_next = res_drive_reg;
        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        if (advance)
        begin
            s1_valid_next  = 1'b0;
            res_valid_next = 1'b1;
            res_drive_next = axis_ok ? step_res.drive : '0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_ch_next    = sample.channel;
            s1_meas_next  = sample.measurement;
            s1_tgt_next   = sample.target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ch_reg     <= s1_ch_next;
        s1_meas_reg   <= s1_meas_next;
        s1_tgt_reg    <= s1_tgt_next;
        res_drive_reg <= res_drive_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                integ_reg[k] <= '0;
                prev_reg[k]  <= '0;
            end
        end
        else if (advance && axis_ok)
        begin
            integ_reg[s1_ch_reg] <= step_res.integ;
            prev_reg[s1_ch_reg]  <= s1_meas_reg;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.drive = res_drive_reg;

    `MAPID_ASSERT_SAME(a_stall_blocks_input, clk, rst_n,
        s1_valid_reg && res_valid_reg && !result.ready, !sample.ready)
    `MAPID_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, res_valid_reg)
    `MAPID_ASSERT_NEXT(a_unused_channel_zero, clk, rst_n,
        advance && (s1_ch_reg == CH_NONE), res_drive_reg == '0)
    `MAPID_ASSERT_NEXT(a_unused_channel_keeps_state, clk, rst_n,
        advance && (s1_ch_reg == CH_NONE),
        $stable(integ_reg[0]) && $stable(integ_reg[1]) && $stable(integ_reg[2]))

endmodule

/* verif/tb_multi_axis_pid_step.sv */
// Self-checking testbench of the three-axis PID step: a directed table, then random phases.
// Depends on mapid_pkg, mapid_if and multi_axis_pid_step; every drive word is checked
// against an axis-state predictor kept in this file or, for fixed rows, a fixed value.
module tb_multi_axis_pid_step;
    timeunit 1ns;
    timeprecision 1ps;

    import mapid_pkg::*;

    localparam cfg_index_t REG_SPARE_A = 3'd6;
    localparam cfg_index_t REG_SPARE_B = 3'd7;
    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;
    localparam int NUM_DIRECTED_ROWS = 25;
    localparam int NUM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 215;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_e;

    typedef struct packed {
        row_kind_e  kind;
        channel_t   ch;
        sample_t    meas;
        sample_t    tgt;
        logic       has_fixed;
        drive_t     fixed_drive;
        cfg_index_t idx;
        cfg_data_t  data;
    } stim_row_t;

    logic clk;
    logic rst_n;

    mapid_in_if  sample_if();
    mapid_out_if result_if();
    mapid_cfg_if cfg_if();

    multi_axis_pid_step i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    logic [GAINS_W-1:0]  axis_gains  [NUM_AXES] = '{default: '0};
    logic [LIMITS_W-1:0] axis_limits [NUM_AXES] = '{default: '0};
    integ_t              integ_state [NUM_AXES] = '{default: '0};
    sample_t             prev_meas   [NUM_AXES] = '{default: '0};

    drive_t    pending_drives [$];
    int        error_count = 0;
    stim_row_t directed_rows [NUM_DIRECTED_ROWS];

    function automatic drive_t predict_drive(channel_t ch, sample_t m, sample_t t);
        gain_t  kp;
        gain_t  ki;
        gain_t  kd;
        limit_t hi;
        limit_t lo;
        longint err;
        longint dmeas;
        longint acc;
        longint drv;
        if (ch == CH_NONE)
        begin
            return '0;
        end
        {kp, ki, kd} = axis_gains[ch];
        {hi, lo} = axis_limits[ch];
        err = longint'(t) - longint'(m);
        dmeas = longint'(m) - longint'(prev_meas[ch]);
        acc = longint'(integ_state[ch]) + longint'(ki) * err;
        if (acc > hi)
        begin
            acc = hi;
        end
        else if (acc < lo)
        begin
            acc = lo;
        end
        integ_state[ch] = integ_t'(acc);
        prev_meas[ch] = m;
        drv = longint'(kp) * err + acc - longint'(kd) * dmeas;
        return drive_t'(drv);
    endfunction

    function automatic void apply_reg_write(cfg_index_t idx, cfg_data_t data);
        if (idx <= REG_GAINS_YAW)
        begin
            axis_gains[idx] = data[GAINS_W-1:0];
        end
        else if (idx <= REG_LIMITS_YAW)
        begin
            axis_limits[idx - REG_LIMITS_PITCH] = data;
        end
    endfunction

    function automatic stim_row_t word_row(channel_t ch, sample_t m, sample_t t);
        stim_row_t row;
        row = '0;
        row.kind = ROW_WORD;
        row.ch = ch;
        row.meas = m;
        row.tgt = t;
        return row;
    endfunction

    function automatic stim_row_t fixed_row(channel_t ch, sample_t m, sample_t t, drive_t d);
        stim_row_t row;
        row = word_row(ch, m, t);
        row.has_fixed = 1'b1;
        row.fixed_drive = d;
        return row;
    endfunction

    function automatic stim_row_t reg_row(cfg_index_t idx, cfg_data_t data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic sample_t pick_extreme();
        case ($urandom_range(0, 4))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2: return '0;
            3: return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    function automatic gain_t pick_gain(int mode);
        case (mode % 3)
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: return gain_t'($urandom_range(0, 1023)) - 16'sd512;
            default: return gain_t'($urandom);
        endcase
    endfunction

    function automatic cfg_data_t pick_limits(int mode);
        limit_t hi;
        limit_t lo;
        case (mode % 3)
            0: return {32'h7FFF_FFFF, 32'h8000_0000};
            1:
            begin
                hi = limit_t'($urandom_range(0, 1 << 24));
                lo = -limit_t'($urandom_range(0, 1 << 24));
                if ($urandom_range(0, 3) == 0)
                begin
                    return {lo, hi};
                end
                return {hi, lo};
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(channel_t ch, sample_t m, sample_t t, logic has_fixed,
                             drive_t fixed_drive);
        drive_t predicted;
        logic   taken;
        sample_if.valid <= 1'b1;
        sample_if.channel <= ch;
        sample_if.measurement <= m;
        sample_if.target <= t;
        do
        begin
            @(negedge clk);
            taken = sample_if.ready;
            @(posedge clk);
        end
        while (!taken);
        predicted = predict_drive(ch, m, t);
        pending_drives.push_back(has_fixed ? fixed_drive : predicted);
    endtask

    task automatic write_reg(cfg_index_t idx, cfg_data_t data);
        logic taken;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do
        begin
            @(negedge clk);
            taken = cfg_if.ready;
            @(posedge clk);
        end
        while (!taken);
        apply_reg_write(idx, data);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off new words until every drive word has come back, then let the pipe settle.
    task automatic wait_drained();
        sample_if.valid <= 1'b0;
        while (pending_drives.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : drive_ready
        int unsigned rx_cycle;
        int unsigned rx_mode;
        rx_cycle = 0;
        rx_mode = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_cycle % 48 == 0)
            begin
                rx_mode = $urandom_range(0, 3);
            end
            case (rx_mode)
                0: result_if.ready <= 1'b1;
                1: result_if.ready <= 1'($urandom_range(0, 1));
                2: result_if.ready <= ($urandom_range(0, 3) == 0);
                default: result_if.ready <= (rx_cycle % 5) > 1;
            endcase
            rx_cycle++;
        end
    end

    always @(negedge clk)
    begin
        drive_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_drives.size() == 0)
            begin
                $error("drive: expected no word, got %0d", result_if.drive);
                error_count++;
            end
            else
            begin
                want = pending_drives.pop_front();
                if (result_if.drive !== want)
                begin
                    $error("drive: expected %0d, got %0d", want, result_if.drive);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        channel_t ch;
        sample_t  m;
        sample_t  t;
        int       burst_left;
        int       gap;
        rst_n <= 1'b0;
        sample_if.valid <= 1'b0;
        sample_if.channel <= CH_PITCH;
        sample_if.measurement <= '0;
        sample_if.target <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_GAINS_PITCH;
        cfg_if.data <= '0;

        // With all gains zero after reset, the words before the first register write all give a zero drive.
        directed_rows = '{
            fixed_row(CH_PITCH, '0, '0, '0),
            fixed_row(CH_ROLL, SAMPLE_MIN, SAMPLE_MAX, '0),
            fixed_row(CH_YAW, SAMPLE_MAX, SAMPLE_MIN, '0),
            fixed_row(CH_NONE, SAMPLE_MAX, SAMPLE_MAX, '0),
            reg_row(REG_GAINS_PITCH, {16'hDEAD, 16'h7FFF, 16'h8000, 16'h7FFF}),
            reg_row(REG_LIMITS_PITCH, {32'h7FFF_FFFF, 32'h8000_0000}),
            reg_row(REG_GAINS_ROLL, {16'h0000, 16'h8000, 16'h7FFF, 16'h8000}),
            reg_row(REG_LIMITS_ROLL, {32'h0000_0000, 32'h8000_0000}),
            reg_row(REG_GAINS_YAW, {16'h0000, 16'h0100, 16'h0100, 16'h0100}),
            reg_row(REG_LIMITS_YAW, {32'hFFFF_FF00, 32'h0000_0100}),
            word_row(CH_PITCH, SAMPLE_MIN, SAMPLE_MAX),
            word_row(CH_PITCH, SAMPLE_MAX, SAMPLE_MIN),
            word_row(CH_PITCH, SAMPLE_MAX, SAMPLE_MIN),
            word_row(CH_ROLL, SAMPLE_MIN, SAMPLE_MAX),
            word_row(CH_ROLL, SAMPLE_MAX, SAMPLE_MIN),
            word_row(CH_YAW, 16'sd10, 16'sd20),
            word_row(CH_YAW, 16'sd20, 16'sd10),
            word_row(CH_YAW, '0, '0),
            fixed_row(CH_NONE, SAMPLE_MIN, SAMPLE_MIN, '0),
            word_row(CH_YAW, 16'sd1, 16'sd2),
            reg_row(REG_SPARE_A, '1),
            reg_row(REG_SPARE_B, '1),
            word_row(CH_PITCH, -16'sd1, 16'sd1),
            word_row(CH_ROLL, '0, -16'sd1),
            word_row(CH_YAW, '0, '0)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_REG)
            begin
                wait_drained();
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            end
            else
            begin
                send_word(directed_rows[r].ch, directed_rows[r].meas, directed_rows[r].tgt,
                          directed_rows[r].has_fixed, directed_rows[r].fixed_drive);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            for (int axis = 0; axis < NUM_AXES; axis++)
            begin
                write_reg(cfg_index_t'(REG_GAINS_PITCH + axis),
                          {16'($urandom), pick_gain(phase), pick_gain(phase), pick_gain(phase)});
                write_reg(cfg_index_t'(REG_LIMITS_PITCH + axis), pick_limits(phase));
            end
            write_reg(phase[0] ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
            burst_left = $urandom_range(1, 24);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                ch = ($urandom_range(0, 15) == 0) ? CH_NONE : channel_t'($urandom_range(0, 2));
                case ($urandom_range(0, 3))
                    0, 1:
                    begin
                        m = sample_t'($urandom);
                        t = sample_t'($urandom);
                    end
                    2:
                    begin
                        m = pick_extreme();
                        t = pick_extreme();
                    end
                    default:
                    begin
                        m = (ch == CH_NONE) ? sample_t'(0) : prev_meas[ch];
                        m = m + sample_t'($urandom_range(0, 64)) - 16'sd32;
                        t = m + sample_t'($urandom_range(0, 64)) - 16'sd32;
                    end
                endcase
                send_word(ch, m, t, 1'b0, '0);
                if (phase == 3 && n == WORDS_PER_PHASE / 2)
                begin
                    wait_drained();
                end
                else
                begin
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                        if (gap != 0)
                        begin
                            sample_if.valid <= 1'b0;
                            repeat (gap) @(posedge clk);
                        end
                        burst_left = $urandom_range(1, 24);
                    end
                end
            end
        end

        sample_if.valid <= 1'b0;
        while (pending_drives.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
